### hw/rtl/ptick_pkg.sv
package ptick_pkg;

    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned TICK_W    = 64;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [SAMPLE_W-1:0] DIVISOR_RESET = 16'd1193;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_POLL    = 2'd1,
        KIND_QUERY   = 2'd2,
        KIND_RESTART = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIVISOR = 2'd0,
        CFG_MODE    = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] divisor;    // effective divisor, never zero
        logic                intr_mode;
    } cfg_t;

    typedef struct packed {
        kind_t               kind;
        logic [SAMPLE_W-1:0] sample;
        logic [TICK_W-1:0]   start;
        logic [TICK_W-1:0]   start_m1;   // start - 1, for the carry case
        logic [TICK_W-1:0]   duration;
    } item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] cur;        // clamped sample
        logic [SAMPLE_W-1:0] prev_next;
        logic [SAMPLE_W-1:0] rem_next;
        logic                carry;
    } samp_t;

endpackage

### hw/rtl/ptick_sampler.sv
module ptick_sampler (
    input  ptick_pkg::cfg_t                  cfg,
    input  logic [ptick_pkg::SAMPLE_W-1:0]   sample,
    input  logic [ptick_pkg::SAMPLE_W-1:0]   prev,
    input  logic [ptick_pkg::SAMPLE_W-1:0]   rem,
    output ptick_pkg::samp_t                 res
);
    import ptick_pkg::*;

    logic [SAMPLE_W-1:0] div;
    logic [SAMPLE_W-1:0] cur;
    logic [SAMPLE_W-1:0] last;
    logic [SAMPLE_W-1:0] rem_c;
    logic [SAMPLE_W-1:0] moved;
    logic [SAMPLE_W:0]   sum;
    logic [SAMPLE_W:0]   sum_wrap;

    always_comb
    begin
        div   = cfg.divisor;
        cur   = (sample > div) ? div : sample;
        last  = (prev > div) ? div : prev;
        rem_c = (rem >= div) ? (div - 1'b1) : rem;
        // backward movement wraps through the reload value
        if (cur <= last)
        begin
            moved = last - cur;
        end
        else
        begin
            moved = last + (div - cur);
        end
        sum      = {1'b0, rem_c} + {1'b0, moved};
        sum_wrap = sum - {1'b0, div};

        res.cur = cur;
        if (cfg.intr_mode)
        begin
            res.prev_next = prev;
            res.rem_next  = rem;
            res.carry     = 1'b0;
        end
        else if (sum >= {1'b0, div})
        begin
            res.prev_next = cur;
            res.rem_next  = sum_wrap[SAMPLE_W-1:0];
            res.carry     = 1'b1;
        end
        else
        begin
            res.prev_next = cur;
            res.rem_next  = sum[SAMPLE_W-1:0];
            res.carry     = 1'b0;
        end
    end

endmodule

### hw/rtl/ptick_datapath.sv
module ptick_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  ptick_pkg::item_t               item,
    input  ptick_pkg::cfg_t                cfg,
    output logic [ptick_pkg::TICK_W-1:0]   tick_value,
    output logic                           expired
);
    import ptick_pkg::*;

    logic [SAMPLE_W-1:0] prev_reg, prev_next;
    logic [SAMPLE_W-1:0] rem_reg, rem_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [TICK_W-1:0]   diff0;
    logic [TICK_W-1:0]   diff1;
    samp_t               samp;

    ptick_sampler u_sampler (
        .cfg    (cfg),
        .sample (item.sample),
        .prev   (prev_reg),
        .rem    (rem_reg),
        .res    (samp)
    );

    // elapsed for both carry outcomes, picked after the sampler settles
    assign diff0 = tick_reg - item.start;
    assign diff1 = tick_reg - item.start_m1;

    always_comb
    begin
        prev_next = prev_reg;
        rem_next  = rem_reg;
        tick_next = tick_reg;
        expired   = 1'b0;
        case (item.kind)
            KIND_TICK:
            begin
                tick_next = tick_reg + 1'b1;
            end
            KIND_POLL:
            begin
                prev_next = samp.prev_next;
                rem_next  = samp.rem_next;
                tick_next = tick_reg + {{(TICK_W-1){1'b0}}, samp.carry};
            end
            KIND_QUERY:
            begin
                prev_next = samp.prev_next;
                rem_next  = samp.rem_next;
                tick_next = tick_reg + {{(TICK_W-1){1'b0}}, samp.carry};
                expired   = samp.carry ? (diff1 >= item.duration)
                                       : (diff0 >= item.duration);
            end
            KIND_RESTART:
            begin
                prev_next = samp.cur;
                rem_next  = '0;
                tick_next = '0;
            end
            default:
            begin
                tick_next = tick_reg;
            end
        endcase
    end

    assign tick_value = tick_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            rem_reg  <= '0;
            tick_reg <= '0;
        end
        else if (step)
        begin
            prev_reg <= prev_next;
            rem_reg  <= rem_next;
            tick_reg <= tick_next;
        end
    end

    a_tick_inc: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.kind == KIND_TICK |=> tick_reg == $past(tick_reg) + 1'b1)
        else $error("tick event did not add one");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.kind == KIND_RESTART |=> tick_reg == '0 && rem_reg == '0)
        else $error("restart left count or remainder");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        step && !cfg.intr_mode && (item.kind == KIND_POLL || item.kind == KIND_QUERY)
        |=> rem_reg < $past(cfg.divisor))
        else $error("remainder not below divisor after sample");

endmodule

### hw/rtl/polled_downcounter_tick_accumulator_unit.sv
// channel | direction | beat contents                          | handshake
// in      | input     | kind, counter_sample, start_tick, dur. | in_valid / in_ready
// out     | output    | tick_value, expired                    | out_valid / out_ready
// cfg     | input     | cfg_index, cfg_data                    | cfg_we, no wait
//
// a beat lands in the input register, its result in the output register once that register is free or being drained
// sustained rate is one beat per cycle while the output is not stalled; the loop is the registered state update
// through the sub-tick sampler and the 64-bit tick adder
// a stalled output holds its beat and the input register, then the input side stalls
// reset clears all valid flags, the tick state and loads the default divisor
module polled_downcounter_tick_accumulator_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          kind,
    input  logic [ptick_pkg::SAMPLE_W-1:0]      counter_sample,
    input  logic [ptick_pkg::TICK_W-1:0]        start_tick,
    input  logic [ptick_pkg::TICK_W-1:0]        duration,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ptick_pkg::TICK_W-1:0]        tick_value,
    output logic                                expired,
    input  logic                                cfg_we,
    input  logic [ptick_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptick_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ptick_pkg::*;

    // configuration registers
    logic [SAMPLE_W-1:0] divisor_reg;
    logic                mode_reg;
    cfg_t                cfg;

    // input stage
    logic                s1_valid_reg, s1_valid_next;
    item_t               item_reg;
    logic                accept;
    logic                step;

    // output stage
    logic                out_valid_reg, out_valid_next;
    logic [TICK_W-1:0]   tick_out_reg;
    logic                expired_out_reg;
    logic [TICK_W-1:0]   dp_tick;
    logic                dp_expired;

    // a zero divisor behaves as one
    assign cfg.divisor   = (divisor_reg == '0) ? {{(SAMPLE_W-1){1'b0}}, 1'b1} : divisor_reg;
    assign cfg.intr_mode = mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg <= DIVISOR_RESET;
            mode_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DIVISOR: divisor_reg <= cfg_data;
                CFG_MODE:    mode_reg    <= cfg_data[0];
                default:     mode_reg    <= mode_reg;
            endcase
        end
    end

    // the item is worked off whenever the output register is free or being drained
    assign step     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || step;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.kind     <= kind_t'(kind);
            item_reg.sample   <= counter_sample;
            item_reg.start    <= start_tick;
            // precompute start - 1 so the carry case needs no extra adder
            item_reg.start_m1 <= start_tick - 1'b1;
            item_reg.duration <= duration;
        end
        if (step)
        begin
            tick_out_reg    <= dp_tick;
            expired_out_reg <= dp_expired;
        end
    end

    ptick_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .item       (item_reg),
        .cfg        (cfg),
        .tick_value (dp_tick),
        .expired    (dp_expired)
    );

    assign out_valid  = out_valid_reg;
    assign tick_value = tick_out_reg;
    assign expired    = expired_out_reg;

    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !step |=> s1_valid_reg)
        else $error("pending beat dropped from input register");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty output register");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without a pending beat");

endmodule

### tb/tb_polled_downcounter_tick_accumulator_unit.sv
module tb_polled_downcounter_tick_accumulator_unit;

    import ptick_pkg::*;

    // cycles with no beat on either channel before the run is declared hung
    localparam int unsigned HANG_LIMIT    = 2000;
    // quiet cycles after the last result before a register write or the verdict
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned PHASE_ITEMS   = 147;
    localparam int unsigned NUM_ROWS      = 27;
    localparam logic [TICK_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic [TICK_W-1:0] tick;
        logic              hit;
    } tick_beat_t;

    // one line of the directed table: either a register write or an input beat,
    // with a hand-written expectation where it is obvious
    typedef struct {
        bit                  is_cfg;
        cfg_idx_t            idx;
        logic [15:0]         cval;
        kind_t               kind;
        logic [SAMPLE_W-1:0] sample;
        logic [TICK_W-1:0]   start;
        logic [TICK_W-1:0]   dur;
        bit                  typed;
        logic [TICK_W-1:0]   exp_tick;
        bit                  exp_hit;
    } row_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    kind_t                   kind;
    logic [SAMPLE_W-1:0]     counter_sample;
    logic [TICK_W-1:0]       start_tick;
    logic [TICK_W-1:0]       duration;
    logic                    out_valid;
    logic                    out_ready;
    logic [TICK_W-1:0]       tick_value;
    logic                    expired;
    logic                    cfg_we;
    cfg_idx_t                cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // hand-written expectation travelling with the beat on the input side
    bit                      row_typed;
    logic [TICK_W-1:0]       typed_tick;
    bit                      typed_hit;

    // shadow copy of the block's registers and tick state
    logic [SAMPLE_W-1:0]     divisor_cfg = DIVISOR_RESET;
    logic                    intr_cfg    = 1'b0;
    logic [SAMPLE_W-1:0]     last_count  = '0;
    logic [SAMPLE_W-1:0]     frac_acc    = '0;
    logic [TICK_W-1:0]       ticks_now   = '0;

    tick_beat_t              pending_ticks[$];
    int unsigned             mismatches = 0;
    int unsigned             hang_cycles = 0;
    bit                      quiet = 1'b0;   // no idling on either side while set

    row_t                    directed_rows [NUM_ROWS];

    polled_downcounter_tick_accumulator_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .counter_sample (counter_sample),
        .start_tick     (start_tick),
        .duration       (duration),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .tick_value     (tick_value),
        .expired        (expired),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // apply one beat to the shadow state and return the tick count and expiry it implies
    function automatic tick_beat_t advance_tick_counter(kind_t k, logic [SAMPLE_W-1:0] raw,
            logic [TICK_W-1:0] st, logic [TICK_W-1:0] dur);
        int unsigned div;
        int unsigned cur;
        int unsigned last;
        int unsigned acc;
        int unsigned moved;
        tick_beat_t  beat;
        div = (divisor_cfg == '0) ? 1 : divisor_cfg;
        cur = (raw > div) ? div : raw;
        beat.hit = 1'b0;
        // polled mode: count how far the down-counter moved, carry whole periods
        if ((k == KIND_POLL || k == KIND_QUERY) && !intr_cfg)
        begin
            last  = (last_count > div) ? div : last_count;
            acc   = (frac_acc >= div) ? div - 1 : frac_acc;
            moved = (cur <= last) ? last - cur : last + div - cur;
            acc   = acc + moved;
            if (acc >= div)
            begin
                acc       = acc - div;
                ticks_now = ticks_now + 64'd1;
            end
            last_count = cur[SAMPLE_W-1:0];
            frac_acc   = acc[SAMPLE_W-1:0];
        end
        case (k)
            KIND_TICK:    ticks_now = ticks_now + 64'd1;
            KIND_QUERY:   beat.hit = ((ticks_now - st) >= dur);
            KIND_RESTART:
            begin
                ticks_now  = '0;
                frac_acc   = '0;
                last_count = cur[SAMPLE_W-1:0];
            end
            default: ;
        endcase
        beat.tick = ticks_now;
        return beat;
    endfunction

    // everything that happens at a clock edge is seen here in one place, so an
    // expectation is always queued before the result of the same edge is popped
    always @(posedge clk)
    begin : scoreboard
        tick_beat_t want;
        tick_beat_t got;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_DIVISOR)
                    divisor_cfg = cfg_data;
                else if (cfg_index == CFG_MODE)
                    intr_cfg = cfg_data[0];
            end
            if (in_valid && in_ready)
            begin
                want = advance_tick_counter(kind, counter_sample, start_tick, duration);
                if (row_typed)
                    want = '{tick: typed_tick, hit: typed_hit};
                pending_ticks.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                got = '{tick: tick_value, hit: expired};
                if (pending_ticks.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: tick_value %0d expired %0b",
                             $time, got.tick, got.hit);
                    mismatches++;
                end
                else
                begin
                    want = pending_ticks.pop_front();
                    if (got.tick !== want.tick)
                    begin
                        $display("%0t: tick_value mismatch: expected %0d actual %0d",
                                 $time, want.tick, got.tick);
                        mismatches++;
                    end
                    if (got.hit !== want.hit)
                    begin
                        $display("%0t: expired mismatch: expected %0b actual %0b",
                                 $time, want.hit, got.hit);
                        mismatches++;
                    end
                end
            end
        end
    end

    // hang detection: any cycle without a beat on either side counts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                hang_cycles = 0;
            else
                hang_cycles++;
            if (hang_cycles >= HANG_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles, %0d results outstanding",
                         $time, HANG_LIMIT, pending_ticks.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // result side: random stall before each beat, none while quiet
    initial
    begin : result_sink
        int unsigned stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // present one beat, optional gap first; returns at the falling edge after acceptance
    task automatic send_item(input kind_t k, input logic [SAMPLE_W-1:0] s,
            input logic [TICK_W-1:0] st, input logic [TICK_W-1:0] dur,
            input bit typed, input logic [TICK_W-1:0] et, input bit eh);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        kind           <= k;
        counter_sample <= s;
        start_tick     <= st;
        duration       <= dur;
        row_typed      <= typed;
        typed_tick     <= et;
        typed_hit      <= eh;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // hold the sender off until every queued result has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_ticks.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // registers change only with the block idle
    task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        int unsigned         phase;
        int unsigned         n;
        int unsigned         r;
        int unsigned         pick;
        int unsigned         step;
        int unsigned         pos;
        int unsigned         ediv;
        logic [15:0]         div_set;
        logic                mode_set;
        kind_t               k;
        logic [SAMPLE_W-1:0] s;
        logic [TICK_W-1:0]   st;
        logic [TICK_W-1:0]   dur;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        kind           = KIND_TICK;
        counter_sample = '0;
        start_tick     = '0;
        duration       = '0;
        out_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_DIVISOR;
        cfg_data       = '0;
        row_typed      = 1'b0;
        typed_tick     = '0;
        typed_hit      = 1'b0;

        // default divisor, polled mode; then zero divisor, full-scale divisor,
        // a lowered divisor that leaves a stale sample and remainder, interrupt mode, then default divisor polled again
        directed_rows = '{
            '{0, CFG_DIVISOR, 0, KIND_TICK,    16'd0,     64'd0,    64'd0,    1, 64'd1, 0},
            '{0, CFG_DIVISOR, 0, KIND_POLL,    16'd0,     64'd0,    64'd0,    0, 64'd0, 0},
            '{0, CFG_DIVISOR, 0, KIND_POLL,    16'hFFFF,  64'd0,    64'd0,    0, 64'd0, 0},
            '{0, CFG_DIVISOR, 0, KIND_POLL,    16'd0,     64'd0,    64'd0,    0, 64'd0, 0},
            '{0, CFG_DIVISOR, 0, KIND_QUERY,   16'd600,   64'd0,    64'd0,    0, 64'd0, 0},
            '{0, CFG_DIVISOR, 0, KIND_QUERY,   16'd0,     ALL_ONES, ALL_ONES, 0, 64'd0, 0},
            '{0, CFG_DIVISOR, 0, KIND_RESTART, 16'd1000,  64'd0,    64'd0,    1, 64'd0, 0},
            '{1, CFG_DIVISOR, 16'd0, KIND_TICK, 16'd0,    64'd0,    64'd0,    0, 64'd0, 0},
            '{0, CFG_DIVISOR, 0, KIND_POLL,    16'd0,     64'd0,    64'd0,    0, 64'd0, 0},
            '{0, CFG_DIVISOR, 0, KIND_POLL,    16'd1,     64'd0,    64'd0,    0, 64'd0, 0},
            '{0, CFG_DIVISOR, 0, KIND_QUERY,   16'd5,     64'd1,    64'd1,    0, 64'd0, 0},
            '{1, CFG_DIVISOR, 16'hFFFF, KIND_TICK, 16'd0, 64'd0,    64'd0,    0, 64'd0, 0},
            '{0, CFG_DIVISOR, 0, KIND_POLL,    16'd5000,  64'd0,    64'd0,    0, 64'd0, 0},
            '{1, CFG_DIVISOR, 16'd100, KIND_TICK, 16'd0,  64'd0,    64'd0,    0, 64'd0, 0},
            '{0, CFG_DIVISOR, 0, KIND_POLL,    16'd50,    64'd0,    64'd0,    0, 64'd0, 0},
            '{1, CFG_MODE,    16'd1, KIND_TICK, 16'd0,    64'd0,    64'd0,    0, 64'd0, 0},
            '{0, CFG_DIVISOR, 0, KIND_POLL,    16'd7,     64'd0,    64'd0,    0, 64'd0, 0},
            '{0, CFG_DIVISOR, 0, KIND_TICK,    16'd0,     64'd0,    64'd0,    0, 64'd0, 0},
            '{0, CFG_DIVISOR, 0, KIND_QUERY,   16'd3,     64'd0,    64'd2,    0, 64'd0, 0},
            '{0, CFG_DIVISOR, 0, KIND_RESTART, 16'hFFFF,  64'd0,    64'd0,    1, 64'd0, 0},
            '{0, CFG_DIVISOR, 0, KIND_TICK,    16'd0,     64'd0,    64'd0,    1, 64'd1, 0},
            '{1, CFG_MODE,    16'd0, KIND_TICK, 16'd0,    64'd0,    64'd0,    0, 64'd0, 0},
            '{1, CFG_DIVISOR, 16'd1193, KIND_TICK, 16'd0, 64'd0,    64'd0,    0, 64'd0, 0},
            '{0, CFG_DIVISOR, 0, KIND_POLL,    16'd0,     64'd0,    64'd0,    0, 64'd0, 0},
            '{0, CFG_DIVISOR, 0, KIND_QUERY,   16'd1193,  ALL_ONES, 64'd1,    0, 64'd0, 0},
            '{0, CFG_DIVISOR, 0, KIND_QUERY,   16'd0,     64'd5,    ALL_ONES, 0, 64'd0, 0},
            '{0, CFG_DIVISOR, 0, KIND_RESTART, 16'd0,     64'd0,    64'd0,    1, 64'd0, 0}
        };

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_register(directed_rows[i].idx, directed_rows[i].cval);
            else
                send_item(directed_rows[i].kind, directed_rows[i].sample,
                          directed_rows[i].start, directed_rows[i].dur,
                          directed_rows[i].typed, directed_rows[i].exp_tick,
                          directed_rows[i].exp_hit);
        end

        // random phases, each with its own divisor and mode
        for (phase = 0; phase < 7; phase++)
        begin
            mode_set = 1'b0;
            case (phase)
                0: div_set = 16'd1193;
                1: div_set = 16'd1;
                2: div_set = 16'hFFFF;
                3: div_set = 16'd0;
                4: div_set = 16'($urandom_range(2, 40));
                5:
                begin
                    div_set  = 16'($urandom_range(0, 65535));
                    mode_set = 1'b1;
                end
                default: div_set = 16'($urandom_range(41, 65535));
            endcase
            write_register(CFG_DIVISOR, div_set);
            write_register(CFG_MODE, {15'd0, mode_set});
            ediv = (div_set == 16'd0) ? 1 : div_set;
            pos  = $urandom_range(0, ediv);

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 40 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                // mid-phase drain with the block left running
                if (n == PHASE_ITEMS / 2 && phase % 2 == 0)
                    wait_for_results();

                // mostly a down-counter moving by less than a period, some raw noise
                pick = $urandom_range(0, 9);
                if (pick < 8)
                begin
                    step = $urandom_range(0, ediv);
                    pos  = (pos >= step) ? pos - step : pos + ediv - step;
                    s    = pos[SAMPLE_W-1:0];
                end
                else if (pick == 8)
                    s = SAMPLE_W'($urandom_range(0, 65535));
                else
                begin
                    case ($urandom_range(0, 2))
                        0:       s = '0;
                        1:       s = ediv[SAMPLE_W-1:0];
                        default: s = '1;
                    endcase
                end

                r = $urandom_range(0, 99);
                if (r < 15)
                    k = KIND_TICK;
                else if (r < 58)
                    k = KIND_POLL;
                else if (r < 85)
                    k = KIND_QUERY;
                else if (r < 89)
                    k = KIND_RESTART;
                else
                begin
                    k = ($urandom_range(0, 1) != 0) ? KIND_POLL : KIND_QUERY;
                    s = SAMPLE_W'($urandom_range(0, 65535));
                end

                // half the intervals near the current count so both answers come up, the rest random or at the extremes
                case ($urandom_range(0, 3))
                    0, 1:
                    begin
                        st  = ticks_now - TICK_W'($urandom_range(0, 6));
                        dur = TICK_W'($urandom_range(0, 8));
                    end
                    2:
                    begin
                        st  = {$urandom, $urandom};
                        dur = {$urandom, $urandom};
                    end
                    default:
                    begin
                        st  = ($urandom_range(0, 1) != 0) ? ALL_ONES : '0;
                        dur = ($urandom_range(0, 1) != 0) ? ALL_ONES : '0;
                    end
                endcase

                send_item(k, s, st, dur, 1'b0, '0, 1'b0);
            end
        end

        quiet = 1'b0;
        wait_for_results();
        repeat (10) @(negedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
